>>> src/cpa_pkg.sv
// shared constants for the contiguous page allocator
`timescale 1ns / 1ps

package cpa_pkg;

  localparam int OPCODE_W = 2;
  localparam int PID_W    = 16;
  localparam int REQ_W    = 11;
  localparam int PGNUM_W  = 10;
  localparam int BASE_W   = 10;
  localparam int FRAME_W  = 11;
  localparam int ADDR_W   = 23;
  localparam int TOTAL_W  = 11;
  localparam int PSIZE_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOCATE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam logic KIND_FINAL = 1'b0;
  localparam logic KIND_MOVE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 1'd1;

  localparam logic [TOTAL_W-1:0] TOTAL_PAGES_RST = 11'd1024;
  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 13'd256;

endpackage

>>> src/cpa_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface cpa_in_if;
  logic                             valid;
  logic                             ready;
  logic [cpa_pkg::OPCODE_W-1:0]     opcode;
  logic [cpa_pkg::PID_W-1:0]        pid;
  logic [cpa_pkg::REQ_W-1:0]        pages_requested;
  logic [cpa_pkg::PGNUM_W-1:0]      page_number;

  modport source (output valid, opcode, pid, pages_requested, page_number, input ready);
  modport sink (input valid, opcode, pid, pages_requested, page_number, output ready);
endinterface

interface cpa_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [1:0]                       status;
  logic [cpa_pkg::BASE_W-1:0]       base_frame;
  logic [cpa_pkg::FRAME_W-1:0]      frame;
  logic [cpa_pkg::ADDR_W-1:0]       byte_address;
  logic [cpa_pkg::BASE_W-1:0]       move_from;
  logic [cpa_pkg::BASE_W-1:0]       move_to;
  logic [cpa_pkg::REQ_W-1:0]        move_pages;
  logic                             last;

  modport source (output valid, kind, status, base_frame, frame, byte_address, move_from,
                  move_to, move_pages, last, input ready);
  modport sink (input valid, kind, status, base_frame, frame, byte_address, move_from,
                move_to, move_pages, last, output ready);
endinterface

>>> src/contiguous_page_allocator_top.sv
// contiguous page allocator: sequencer over page bitmap and process table
// allocate: scans the bitmap up to min(total_pages, NUM_PAGES), then marks the pages of the run;
//   if no run fits, compaction instead moves each process in base order, then rewrites the bitmap
// free: table lookup, then releases the pages; locate: table lookup, then the address multiply
// one request at a time, ready only between requests
// after reset the bitmap is cleared before the first request is taken
`timescale 1ns / 1ps

module contiguous_page_allocator_top #(
  parameter int NUM_PAGES = 1024,
  parameter int MAX_PROCS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cpa_in_if.sink                            in_ch,
  cpa_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int IW  = (PW + 1 > cpa_pkg::REQ_W) ? PW + 1 : cpa_pkg::REQ_W;
  localparam int SW  = $clog2(MAX_PROCS);
  localparam int SCW = SW + 1;
  localparam int DW  = cpa_pkg::PID_W + 2 * IW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ASCAN, S_TSCAN, S_PICK, S_MOVE, S_SWEEP, S_MARK, S_LMUL, S_FINAL
  } state_t;

  state_t state_r, state_nxt;

  logic [cpa_pkg::TOTAL_W-1:0] total_pages_r, total_pages_nxt;
  logic [cpa_pkg::PSIZE_W-1:0] page_size_r, page_size_nxt;

  logic [cpa_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [cpa_pkg::PID_W-1:0]    pid_r, pid_nxt;
  logic [IW-1:0]                n_r, n_nxt;
  logic [cpa_pkg::PGNUM_W-1:0]  pg_r, pg_nxt;

  logic [IW-1:0]  idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic [IW-1:0]  pidx_r, pidx_nxt;
  logic [IW-1:0]  run_r, run_nxt;
  logic [IW-1:0]  freecnt_r, freecnt_nxt;
  logic           found_r, found_nxt;
  logic [IW-1:0]  pos_r, pos_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic           slot_ok_r, slot_ok_nxt;

  logic [SCW-1:0] sidx_r, sidx_nxt;
  logic           spend_r, spend_nxt;
  logic [SW-1:0]  psidx_r, psidx_nxt;

  logic                      best_found_r, best_found_nxt;
  logic [SW-1:0]             best_slot_r, best_slot_nxt;
  logic [IW-1:0]             best_base_r, best_base_nxt;
  logic [IW-1:0]             best_cnt_r, best_cnt_nxt;
  logic [cpa_pkg::PID_W-1:0] best_pid_r, best_pid_nxt;
  logic [MAX_PROCS-1:0]      done_r, done_nxt;
  logic [IW-1:0]             next_r, next_nxt;
  logic [IW-1:0]             fill_end_r, fill_end_nxt;
  logic                      fits_r, fits_nxt;
  logic [IW-1:0]             mark_end_r, mark_end_nxt;
  logic                      mark_val_r, mark_val_nxt;

  logic [MAX_PROCS-1:0] valid_r, valid_nxt;

  logic [1:0]                  fin_status_r, fin_status_nxt;
  logic [IW-1:0]               fin_base_r, fin_base_nxt;
  logic [cpa_pkg::FRAME_W-1:0] fin_frame_r, fin_frame_nxt;
  logic [cpa_pkg::ADDR_W-1:0]  fin_addr_r, fin_addr_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_kind_r, out_kind_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;
  logic [cpa_pkg::BASE_W-1:0]  out_base_r, out_base_nxt;
  logic [cpa_pkg::FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic [cpa_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [cpa_pkg::BASE_W-1:0]  out_from_r, out_from_nxt;
  logic [cpa_pkg::BASE_W-1:0]  out_to_r, out_to_nxt;
  logic [cpa_pkg::REQ_W-1:0]   out_pages_r, out_pages_nxt;
  logic                        out_last_r, out_last_nxt;

  logic          bm_we, bm_wdata, bm_rdata;
  logic [PW-1:0] bm_waddr, bm_raddr;
  logic          tb_we;
  logic [SW-1:0] tb_waddr, tb_raddr;
  logic [DW-1:0] tb_wdata, tb_rdata;

  logic [cpa_pkg::PID_W-1:0] tb_pid;
  logic [IW-1:0]             tb_base, tb_cnt;
  logic [IW-1:0]             lim;
  logic [IW:0]               fit_sum;
  logic                      out_free;
  logic [SW-1:0]             free_slot;
  logic                      free_ok;

  cpa_ram #(.DEPTH(NUM_PAGES), .AW(PW), .DW(1)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  cpa_ram #(.DEPTH(MAX_PROCS), .AW(SW), .DW(DW)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  assign tb_pid  = tb_rdata[DW-1 -: cpa_pkg::PID_W];
  assign tb_base = tb_rdata[2*IW-1 -: IW];
  assign tb_cnt  = tb_rdata[IW-1:0];

  assign lim = (IW'(total_pages_r) < IW'(NUM_PAGES)) ? IW'(total_pages_r) : IW'(NUM_PAGES);
  assign fit_sum  = {1'b0, next_r} + {1'b0, n_r};
  assign out_free = !out_valid_r || out_ch.ready;

  // lowest free table slot
  always_comb begin
    free_slot = '0;
    for (int s = MAX_PROCS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free_slot = SW'(s);
      end
    end
    free_ok = ~&valid_r;
  end

  always_comb begin
    state_nxt       = state_r;
    total_pages_nxt = total_pages_r;
    page_size_nxt   = page_size_r;
    op_nxt          = op_r;
    pid_nxt         = pid_r;
    n_nxt           = n_r;
    pg_nxt          = pg_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    pidx_nxt        = pidx_r;
    run_nxt         = run_r;
    freecnt_nxt     = freecnt_r;
    found_nxt       = found_r;
    pos_nxt         = pos_r;
    slot_nxt        = slot_r;
    slot_ok_nxt     = slot_ok_r;
    sidx_nxt        = sidx_r;
    spend_nxt       = spend_r;
    psidx_nxt       = psidx_r;
    best_found_nxt  = best_found_r;
    best_slot_nxt   = best_slot_r;
    best_base_nxt   = best_base_r;
    best_cnt_nxt    = best_cnt_r;
    best_pid_nxt    = best_pid_r;
    done_nxt        = done_r;
    next_nxt        = next_r;
    fill_end_nxt    = fill_end_r;
    fits_nxt        = fits_r;
    mark_end_nxt    = mark_end_r;
    mark_val_nxt    = mark_val_r;
    valid_nxt       = valid_r;
    fin_status_nxt  = fin_status_r;
    fin_base_nxt    = fin_base_r;
    fin_frame_nxt   = fin_frame_r;
    fin_addr_nxt    = fin_addr_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_base_nxt    = out_base_r;
    out_frame_nxt   = out_frame_r;
    out_addr_nxt    = out_addr_r;
    out_from_nxt    = out_from_r;
    out_to_nxt      = out_to_r;
    out_pages_nxt   = out_pages_r;
    out_last_nxt    = out_last_r;

    bm_we    = 1'b0;
    bm_waddr = idx_r[PW-1:0];
    bm_wdata = 1'b0;
    bm_raddr = idx_r[PW-1:0];
    tb_we    = 1'b0;
    tb_waddr = slot_r;
    tb_wdata = {pid_r, pos_r, n_r};
    tb_raddr = sidx_r[SW-1:0];

    if (cfg_we) begin
      if (cfg_index == cpa_pkg::CFG_TOTAL_PAGES) begin
        total_pages_nxt = cfg_data[cpa_pkg::TOTAL_W-1:0];
      end else begin
        page_size_nxt = cfg_data;
      end
    end

    case (state_r)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_wdata = 1'b0;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == IW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_ch.opcode;
          pid_nxt        = in_ch.pid;
          n_nxt          = IW'(in_ch.pages_requested);
          pg_nxt         = in_ch.page_number;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          run_nxt        = '0;
          freecnt_nxt    = '0;
          found_nxt      = 1'b0;
          sidx_nxt       = '0;
          spend_nxt      = 1'b0;
          slot_nxt       = free_slot;
          slot_ok_nxt    = free_ok;
          fin_status_nxt = cpa_pkg::ST_OK;
          fin_base_nxt   = '0;
          fin_frame_nxt  = '0;
          fin_addr_nxt   = '0;
          case (in_ch.opcode)
            cpa_pkg::OP_ALLOC: begin
              if (in_ch.pages_requested == '0) begin
                fin_status_nxt = cpa_pkg::ST_NO_SPACE;
                state_nxt      = S_FINAL;
              end else begin
                state_nxt = S_ASCAN;
              end
            end
            cpa_pkg::OP_FREE, cpa_pkg::OP_LOCATE: begin
              state_nxt = S_TSCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // one pass gives the free count and the first fitting run
      S_ASCAN: begin
        if (idx_r < lim) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (bm_rdata) begin
            run_nxt = '0;
          end else begin
            run_nxt     = run_r + 1'b1;
            freecnt_nxt = freecnt_r + 1'b1;
            if (!found_r && (run_r + 1'b1 == n_r)) begin
              found_nxt = 1'b1;
              pos_nxt   = pidx_r + 1'b1 - n_r;
            end
          end
        end
        if (idx_r >= lim && !pend_r) begin
          if (freecnt_r < n_r) begin
            fin_status_nxt = cpa_pkg::ST_NO_SPACE;
            state_nxt      = S_FINAL;
          end else if (!slot_ok_r) begin
            fin_status_nxt = cpa_pkg::ST_TABLE_FULL;
            state_nxt      = S_FINAL;
          end else if (found_r) begin
            tb_we              = 1'b1;
            valid_nxt[slot_r]  = 1'b1;
            idx_nxt            = pos_r;
            mark_end_nxt       = pos_r + n_r;
            mark_val_nxt       = 1'b1;
            fin_base_nxt       = pos_r;
            state_nxt          = S_MARK;
          end else begin
            sidx_nxt       = '0;
            spend_nxt      = 1'b0;
            best_found_nxt = 1'b0;
            done_nxt       = '0;
            next_nxt       = '0;
            state_nxt      = S_PICK;
          end
        end
      end

      // lookup of the lowest valid slot holding the pid
      S_TSCAN: begin
        if (sidx_r < SCW'(MAX_PROCS)) begin
          sidx_nxt  = sidx_r + 1'b1;
          spend_nxt = 1'b1;
          psidx_nxt = sidx_r[SW-1:0];
        end else begin
          spend_nxt = 1'b0;
        end
        if (spend_r && valid_r[psidx_r] && tb_pid == pid_r) begin
          if (op_r == cpa_pkg::OP_FREE) begin
            valid_nxt[psidx_r] = 1'b0;
            idx_nxt            = tb_base;
            mark_end_nxt       = tb_base + tb_cnt;
            mark_val_nxt       = 1'b0;
            state_nxt          = S_MARK;
          end else begin
            fin_frame_nxt = cpa_pkg::FRAME_W'(tb_base + IW'(pg_r));
            state_nxt     = S_LMUL;
          end
        end else if (sidx_r == SCW'(MAX_PROCS) && !spend_r) begin
          fin_status_nxt = cpa_pkg::ST_NOT_FOUND;
          state_nxt      = S_FINAL;
        end
      end

      // lowest base among processes not yet packed
      S_PICK: begin
        if (sidx_r < SCW'(MAX_PROCS)) begin
          sidx_nxt  = sidx_r + 1'b1;
          spend_nxt = 1'b1;
          psidx_nxt = sidx_r[SW-1:0];
        end else begin
          spend_nxt = 1'b0;
        end
        if (spend_r && valid_r[psidx_r] && !done_r[psidx_r] &&
            (!best_found_r || tb_base < best_base_r)) begin
          best_found_nxt = 1'b1;
          best_slot_nxt  = psidx_r;
          best_base_nxt  = tb_base;
          best_cnt_nxt   = tb_cnt;
          best_pid_nxt   = tb_pid;
        end
        if (sidx_r == SCW'(MAX_PROCS) && !spend_r) begin
          if (best_found_r) begin
            state_nxt = S_MOVE;
          end else begin
            fits_nxt     = fit_sum <= {1'b0, lim};
            fill_end_nxt = (fit_sum <= {1'b0, lim}) ? fit_sum[IW-1:0] : next_r;
            idx_nxt      = '0;
            state_nxt    = S_SWEEP;
          end
        end
      end

      S_MOVE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = cpa_pkg::KIND_MOVE;
          out_status_nxt = cpa_pkg::ST_OK;
          out_base_nxt   = '0;
          out_frame_nxt  = '0;
          out_addr_nxt   = '0;
          out_from_nxt   = cpa_pkg::BASE_W'(best_base_r);
          out_to_nxt     = cpa_pkg::BASE_W'(next_r);
          out_pages_nxt  = cpa_pkg::REQ_W'(best_cnt_r);
          out_last_nxt   = 1'b0;
          tb_we          = 1'b1;
          tb_waddr       = best_slot_r;
          tb_wdata       = {best_pid_r, next_r, best_cnt_r};
          done_nxt[best_slot_r] = 1'b1;
          next_nxt       = next_r + best_cnt_r;
          sidx_nxt       = '0;
          spend_nxt      = 1'b0;
          best_found_nxt = 1'b0;
          state_nxt      = S_PICK;
        end
      end

      // packed bitmap rewrite, new run included when it fits
      S_SWEEP: begin
        bm_we    = 1'b1;
        bm_wdata = idx_r < fill_end_r;
        idx_nxt  = idx_r + 1'b1;
        if (idx_r == IW'(NUM_PAGES - 1)) begin
          if (fits_r) begin
            tb_we             = 1'b1;
            tb_wdata          = {pid_r, next_r, n_r};
            valid_nxt[slot_r] = 1'b1;
            fin_base_nxt      = next_r;
          end else begin
            fin_status_nxt = cpa_pkg::ST_NO_SPACE;
          end
          state_nxt = S_FINAL;
        end
      end

      S_MARK: begin
        if (idx_r == mark_end_r) begin
          state_nxt = S_FINAL;
        end else begin
          bm_we    = idx_r < IW'(NUM_PAGES);
          bm_wdata = mark_val_r;
          idx_nxt  = idx_r + 1'b1;
        end
      end

      S_LMUL: begin
        fin_addr_nxt = cpa_pkg::ADDR_W'(fin_frame_r) * cpa_pkg::ADDR_W'(page_size_r);
        state_nxt    = S_FINAL;
      end

      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = cpa_pkg::KIND_FINAL;
          out_status_nxt = fin_status_r;
          out_base_nxt   = cpa_pkg::BASE_W'(fin_base_r);
          out_frame_nxt  = fin_frame_r;
          out_addr_nxt   = fin_addr_r;
          out_from_nxt   = '0;
          out_to_nxt     = '0;
          out_pages_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      idx_r         <= '0;
      total_pages_r <= cpa_pkg::TOTAL_PAGES_RST;
      page_size_r   <= cpa_pkg::PAGE_SIZE_RST;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      spend_r       <= 1'b0;
      found_r       <= 1'b0;
      best_found_r  <= 1'b0;
      done_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      total_pages_r <= total_pages_nxt;
      page_size_r   <= page_size_nxt;
      valid_r       <= valid_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_r        <= pend_nxt;
      spend_r       <= spend_nxt;
      found_r       <= found_nxt;
      best_found_r  <= best_found_nxt;
      done_r        <= done_nxt;
    end
    op_r         <= op_nxt;
    pid_r        <= pid_nxt;
    n_r          <= n_nxt;
    pg_r         <= pg_nxt;
    pidx_r       <= pidx_nxt;
    run_r        <= run_nxt;
    freecnt_r    <= freecnt_nxt;
    pos_r        <= pos_nxt;
    slot_r       <= slot_nxt;
    slot_ok_r    <= slot_ok_nxt;
    sidx_r       <= sidx_nxt;
    psidx_r      <= psidx_nxt;
    best_slot_r  <= best_slot_nxt;
    best_base_r  <= best_base_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_pid_r   <= best_pid_nxt;
    next_r       <= next_nxt;
    fill_end_r   <= fill_end_nxt;
    fits_r       <= fits_nxt;
    mark_end_r   <= mark_end_nxt;
    mark_val_r   <= mark_val_nxt;
    fin_status_r <= fin_status_nxt;
    fin_base_r   <= fin_base_nxt;
    fin_frame_r  <= fin_frame_nxt;
    fin_addr_r   <= fin_addr_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_frame_r  <= out_frame_nxt;
    out_addr_r   <= out_addr_nxt;
    out_from_r   <= out_from_nxt;
    out_to_r     <= out_to_nxt;
    out_pages_r  <= out_pages_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.base_frame   = out_base_r;
  assign out_ch.frame        = out_frame_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.move_from    = out_from_r;
  assign out_ch.move_to      = out_to_r;
  assign out_ch.move_pages   = out_pages_r;
  assign out_ch.last         = out_last_r;

endmodule

>>> src/cpa_ram.sv
// single write port, single registered read port memory
`timescale 1ns / 1ps

module cpa_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/cpa_checker.sv
// port level checks for the contiguous page allocator
`timescale 1ns / 1ps

module cpa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_kind,
  input logic [1:0]                        out_status,
  input logic [cpa_pkg::BASE_W-1:0]        out_base_frame,
  input logic [cpa_pkg::FRAME_W-1:0]       out_frame,
  input logic [cpa_pkg::ADDR_W-1:0]        out_byte_address,
  input logic                              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_move_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cpa_pkg::KIND_MOVE |-> !out_last)
    else $error("move word flagged last");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cpa_pkg::KIND_FINAL |-> out_last)
    else $error("final word not flagged last");

  a_busy_in_compaction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cpa_pkg::KIND_MOVE |-> !in_ready)
    else $error("request taken during compaction");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cpa_pkg::KIND_FINAL && out_status != cpa_pkg::ST_OK |->
      out_base_frame == '0 && out_frame == '0 && out_byte_address == '0)
    else $error("error word carries values");

endmodule

bind contiguous_page_allocator_top cpa_checker u_cpa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_kind(out_ch.kind),
  .out_status(out_ch.status),
  .out_base_frame(out_ch.base_frame),
  .out_frame(out_ch.frame),
  .out_byte_address(out_ch.byte_address),
  .out_last(out_ch.last)
);
